// ===== design/assert_macros.svh =====
// Assertion macros shared by the max-pool RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MPS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/mps_pkg.sv =====
// Package for the strided max-pool block: widths, reset values, register indexes,
// geometry and beat metadata structs, small divide helper. No dependencies.
package mps_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 7;
   localparam int PIXEL_BITS_DEF = 16;
   localparam int MAX_HEIGHT     = 4096;

   localparam int COL_W    = 12;  // column index, widest legal line
   localparam int ROW_W    = 12;
   localparam int GEO_W    = 13;  // effective width / height and center trackers
   localparam int RAD_W    = 4;
   localparam int SPAN_W   = 5;
   localparam int STR_W    = 5;
   localparam int BANK_W   = 5;
   localparam int OCOL_W   = 10;
   localparam int OROW_W   = 12;
   localparam int POOL_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [10:0] WIDTH_RST  = 11'd640;
   localparam logic [12:0] HEIGHT_RST = 13'd480;
   localparam logic [2:0]  RADIUS_RST = 3'd4;
   localparam logic [4:0]  STRIDE_RST = 5'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_WINDOW_RADIUS = 2'd2,
      CSR_POOL_STRIDE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GEO_W-1:0]  width;
      logic [GEO_W-1:0]  height;
      logic [RAD_W-1:0]  radius;
      logic [SPAN_W-1:0] span;
      logic [STR_W-1:0]  stride;
      logic [RAD_W-1:0]  radius_div;   // radius / stride
   } geom_type;

   typedef struct packed {
      logic              emit;
      logic              last;
      logic [OCOL_W-1:0] out_col;
      logic [OROW_W-1:0] out_row;
      logic [BANK_W-1:0] bank;
      logic [COL_W-1:0]  col;
   } beat_meta_type;

   // Quotient of a small radius by a nonzero stride; at most seven subtract steps.
   function automatic logic [RAD_W-1:0] div_small(input logic [RAD_W-1:0] num,
                                                  input logic [STR_W-1:0] den);
      logic [RAD_W-1:0] q;
      logic [STR_W-1:0] rem;
      q   = '0;
      rem = STR_W'(num);
      if (den == STR_W'(1)) begin
         q = num;
      end else begin
         for (int i = 0; i < 7; i++) begin
            if (rem >= den) begin
               rem = rem - den;
               q   = q + RAD_W'(1);
            end
         end
      end
      return q;
   endfunction

endpackage

// ===== design/mps_queue.sv =====
// Small first-in first-out queue of registers with occupancy count.
// Standalone; used between front and back and as the result buffer.
module mps_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   output logic                        push_ready,
   input  logic [WIDTH-1:0]            push_data,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output logic [WIDTH-1:0]            pop_data,
   output logic [$clog2(DEPTH+1)-1:0]  count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mps_front.sv =====
// Front end: raster counters, window center tracking and beat classification.
// Uses mps_pkg; feeds the front-to-back queue.
module mps_front #(
   parameter int MAX_WIDTH  = mps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = mps_pkg::MAX_RADIUS_DEF,
   parameter int PIXEL_BITS = mps_pkg::PIXEL_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mps_pkg::geom_type      geom,
   input  logic                   resync_start,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [PIXEL_BITS-1:0]  in_pixel,
   input  logic                   in_frame_start,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [PIXEL_BITS-1:0]  push_pixel,
   output mps_pkg::beat_meta_type push_meta
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int NB = 2 * MAX_RADIUS;
   localparam int BW = (NB > 1) ? $clog2(NB) : 1;
   localparam int GW = mps_pkg::GEO_W;
   localparam int RW = mps_pkg::ROW_W;

   typedef enum logic [2:0] {
      RS_IDLE = 3'b001,
      RS_INIT = 3'b010,
      RS_STEP = 3'b100
   } rs_state_type;

   rs_state_type                  rs_state_ff, rs_state_in;
   logic [CW-1:0]                 col_ff, col_in;
   logic [RW-1:0]                 row_ff, row_in;
   logic [BW-1:0]                 bank_ff, bank_in;
   logic [GW-1:0]                 cx_ff, cx_in, ry_ff, ry_in;
   logic [mps_pkg::OCOL_W-1:0]    ocol_ff, ocol_in;
   logic [mps_pkg::OROW_W-1:0]    orow_ff, orow_in;

   logic [CW-1:0]              c;
   logic [RW-1:0]              rr;
   logic [BW-1:0]              bk;
   logic [GW-1:0]              cx, ry, c_ext, r_ext, span_ext, stride_ext;
   logic [mps_pkg::OCOL_W-1:0] ocol;
   logic [mps_pkg::OROW_W-1:0] orow;
   logic                       col_hit, row_hit, accept, col_step, row_step;

   assign in_ready   = push_ready && (rs_state_ff == RS_IDLE);
   assign push_valid = in_valid && (rs_state_ff == RS_IDLE);
   assign accept     = in_valid && in_ready;
   assign push_pixel = in_pixel;
   assign span_ext   = GW'(geom.span);
   assign stride_ext = GW'(geom.stride);

   always_comb begin
      // frame_start forces the beat to column 0, row 0
      c     = in_frame_start ? '0 : col_ff;
      rr    = in_frame_start ? '0 : row_ff;
      bk    = in_frame_start ? '0 : bank_ff;
      cx    = in_frame_start ? span_ext : cx_ff;
      ry    = in_frame_start ? span_ext : ry_ff;
      ocol  = in_frame_start ? mps_pkg::OCOL_W'(geom.radius_div) : ocol_ff;
      orow  = in_frame_start ? mps_pkg::OROW_W'(geom.radius_div) : orow_ff;
      c_ext = GW'(c);
      r_ext = GW'(rr);
      col_hit = (c_ext == cx);
      row_hit = (r_ext == ry);

      push_meta.emit    = (c_ext < geom.width) && (r_ext < geom.height) && col_hit && row_hit;
      push_meta.last    = ((c_ext + stride_ext) >= geom.width) &&
                          ((r_ext + stride_ext) >= geom.height);
      push_meta.out_col = ocol;
      push_meta.out_row = orow;
      push_meta.bank    = mps_pkg::BANK_W'(bk);
      push_meta.col     = mps_pkg::COL_W'(c);

      col_in      = col_ff;
      row_in      = row_ff;
      bank_in     = bank_ff;
      cx_in       = cx_ff;
      ry_in       = ry_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      rs_state_in = rs_state_ff;
      col_step    = 1'b0;
      row_step    = 1'b0;

      if (accept) begin
         if ((c_ext + GW'(1)) >= geom.width) begin
            col_in  = '0;
            cx_in   = span_ext;
            ocol_in = mps_pkg::OCOL_W'(geom.radius_div);
            if ((r_ext + GW'(1)) >= geom.height) begin
               row_in  = '0;
               bank_in = '0;
               ry_in   = span_ext;
               orow_in = mps_pkg::OROW_W'(geom.radius_div);
            end else begin
               row_in  = rr + RW'(1);
               bank_in = (bk == BW'(NB-1)) ? '0 : bk + BW'(1);
               ry_in   = row_hit ? ry + stride_ext : ry;
               orow_in = row_hit ? orow + mps_pkg::OROW_W'(1) : orow;
            end
         end else begin
            col_in  = c + CW'(1);
            cx_in   = col_hit ? cx + stride_ext : cx;
            ocol_in = col_hit ? ocol + mps_pkg::OCOL_W'(1) : ocol;
            row_in  = rr;
            bank_in = bk;
            ry_in   = ry;
            orow_in = orow;
         end
      end

      // after a geometry change, walk the center trackers up to the current position
      case (rs_state_ff)
         RS_IDLE: begin
            rs_state_in = RS_IDLE;
         end
         RS_INIT: begin
            cx_in       = span_ext;
            ry_in       = span_ext;
            ocol_in     = mps_pkg::OCOL_W'(geom.radius_div);
            orow_in     = mps_pkg::OROW_W'(geom.radius_div);
            rs_state_in = RS_STEP;
         end
         RS_STEP: begin
            col_step = (cx_ff < GW'(col_ff));
            row_step = (ry_ff < GW'(row_ff));
            if (col_step) begin
               cx_in   = cx_ff + stride_ext;
               ocol_in = ocol_ff + mps_pkg::OCOL_W'(1);
            end
            if (row_step) begin
               ry_in   = ry_ff + stride_ext;
               orow_in = orow_ff + mps_pkg::OROW_W'(1);
            end
            rs_state_in = (col_step || row_step) ? RS_STEP : RS_IDLE;
         end
         default: begin
            rs_state_in = RS_INIT;
         end
      endcase
      if (resync_start) begin
         rs_state_in = RS_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_state_ff <= RS_INIT;
         col_ff      <= '0;
         row_ff      <= '0;
         bank_ff     <= '0;
         cx_ff       <= '0;
         ry_ff       <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
      end else begin
         rs_state_ff <= rs_state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         bank_ff     <= bank_in;
         cx_ff       <= cx_in;
         ry_ff       <= ry_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
      end
   end

endmodule

// ===== design/mps_back.sv =====
// Back end: banked line store, column maximum, row window, window maximum, result queue.
// Uses mps_pkg, mps_queue and assert_macros.svh.
`include "assert_macros.svh"
module mps_back #(
   parameter int MAX_WIDTH  = mps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = mps_pkg::MAX_RADIUS_DEF,
   parameter int PIXEL_BITS = mps_pkg::PIXEL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mps_pkg::geom_type              geom,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [PIXEL_BITS-1:0]          in_pixel,
   input  mps_pkg::beat_meta_type         in_meta,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [mps_pkg::POOL_W-1:0]     out_pooled,
   output logic [mps_pkg::OCOL_W-1:0]     out_col,
   output logic [mps_pkg::OROW_W-1:0]     out_row,
   output logic                           out_last
);
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int NB     = 2 * MAX_RADIUS;
   localparam int WL     = 2 * MAX_RADIUS + 1;
   localparam int TN     = 2 ** $clog2(WL);
   localparam int DW     = $clog2(NB) + 1;
   localparam int ODEPTH = 4;
   localparam int OCW    = $clog2(ODEPTH+1);
   localparam int RES_W  = mps_pkg::POOL_W + mps_pkg::OCOL_W + mps_pkg::OROW_W + 1;
   localparam int SW     = mps_pkg::SPAN_W;

   function automatic logic [PIXEL_BITS-1:0] tree_max(input logic [TN-1:0][PIXEL_BITS-1:0] v);
      logic [TN-1:0][PIXEL_BITS-1:0] t;
      t = v;
      for (int l = TN/2; l >= 1; l = l/2) begin
         for (int i = 0; i < l; i++) begin
            t[i] = (t[2*i] > t[2*i+1]) ? t[2*i] : t[2*i+1];
         end
      end
      return t[0];
   endfunction

   logic                            pop;
   logic [CW-1:0]                   col_idx;
   logic [PIXEL_BITS-1:0]           rd_word [NB];
   logic                            s1_v_ff, s2_v_ff;
   mps_pkg::beat_meta_type          s1_meta_ff, s2_meta_ff;
   logic [PIXEL_BITS-1:0]           s1_pix_ff;
   logic [WL-1:0][PIXEL_BITS-1:0]   row_win_ff, row_win_in;
   logic [TN-1:0][PIXEL_BITS-1:0]   col_vec, win_vec;
   logic [PIXEL_BITS-1:0]           colmax, best;
   logic [DW-1:0]                   rows_back;
   logic [OCW-1:0]                  ocount;
   logic [OCW+1:0]                  inflight;
   logic                            res_push, res_ready;
   logic [RES_W-1:0]                res_data, head;

   assign inflight = (OCW+2)'(ocount) + (OCW+2)'(s1_v_ff) + (OCW+2)'(s2_v_ff);
   assign in_ready = (inflight < (OCW+2)'(ODEPTH));
   assign pop      = in_valid && in_ready;
   assign col_idx  = in_meta.col[CW-1:0];

   for (genvar b = 0; b < NB; b++) begin : g_bank
      logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
      logic [PIXEL_BITS-1:0] rd_ff;
      // read old data, then store this row's pixel in its own bank
      always_ff @(posedge clock) begin
         if (pop) begin
            rd_ff <= mem[col_idx];
            if (in_meta.bank == mps_pkg::BANK_W'(b)) begin
               mem[col_idx] <= in_pixel;
            end
         end
      end
      assign rd_word[b] = rd_ff;
   end

   always_comb begin
      col_vec    = '0;
      col_vec[0] = s1_pix_ff;
      rows_back  = '0;
      for (int b = 0; b < NB; b++) begin
         // rows back from this bank to bank b; own bank holds the row 2*MAX_RADIUS up
         if (s1_meta_ff.bank >= mps_pkg::BANK_W'(b)) begin
            rows_back = DW'(s1_meta_ff.bank) - DW'(b);
         end else begin
            rows_back = DW'(s1_meta_ff.bank) + DW'(NB) - DW'(b);
         end
         if (rows_back == '0) begin
            rows_back = DW'(NB);
         end
         col_vec[b+1] = (SW'(rows_back) <= geom.span) ? rd_word[b] : '0;
      end
      colmax     = tree_max(col_vec);
      row_win_in = {row_win_ff[WL-2:0], colmax};

      win_vec = '0;
      for (int k = 0; k < WL; k++) begin
         win_vec[k] = (SW'(k) <= geom.span) ? row_win_ff[k] : '0;
      end
      best = tree_max(win_vec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         row_win_ff <= '0;
      end else begin
         s1_v_ff <= pop;
         s2_v_ff <= s1_v_ff;
         if (s1_v_ff) begin
            row_win_ff <= row_win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_meta_ff <= in_meta;
         s1_pix_ff  <= in_pixel;
      end
      s2_meta_ff <= s1_meta_ff;
   end

   assign res_push = s2_v_ff && s2_meta_ff.emit;
   assign res_data = {mps_pkg::POOL_W'(best), s2_meta_ff.out_col,
                      s2_meta_ff.out_row, s2_meta_ff.last};

   mps_queue #(
      .WIDTH (RES_W),
      .DEPTH (ODEPTH)
   ) u_res_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_push),
      .push_ready (res_ready),
      .push_data  (res_data),
      .pop_valid  (out_valid),
      .pop_ready  (out_ready),
      .pop_data   (head),
      .count      (ocount)
   );

   assign out_pooled = head[RES_W-1 -: mps_pkg::POOL_W];
   assign out_col    = head[mps_pkg::OROW_W+1 +: mps_pkg::OCOL_W];
   assign out_row    = head[1 +: mps_pkg::OROW_W];
   assign out_last   = head[0];

   `MPS_ASSERT_IMPL(a_res_room, res_push, res_ready, "result pushed into full queue")
   `MPS_ASSERT(a_credit, inflight <= (OCW+2)'(ODEPTH), "back end over its result credit")
   `MPS_ASSERT_IMPL(a_bank_range, s1_v_ff, s1_meta_ff.bank < mps_pkg::BANK_W'(NB), "bank out of range")

endmodule

// ===== design/max_pool_subsample_top.sv =====
// Top level of the strided max-pool block: configuration registers and the
// front / queue / back chain. Uses mps_pkg, mps_front, mps_queue, mps_back.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_pixel, req_frame_start
//  rsp     | out       | rsp_valid / rsp_ready | rsp_pooled, rsp_out_col, rsp_out_row,
//          |           |                       | rsp_frame_last
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One pixel beat per cycle sustained while rsp_ready is high and no tracker walk
// runs; a result passes the queue, line store read, column max and window max.
// The line store is one single-port-read memory per buffered row, all read in parallel.
// Synchronous active-high reset; line store contents are not cleared.
// After reset and after each csr write the front walks its window-center
// trackers to the raster position, one stride a cycle, with req_ready low.
// rsp stalls back up through a four-entry result queue.
`include "assert_macros.svh"
module max_pool_subsample_top #(
   parameter int MAX_WIDTH  = mps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = mps_pkg::MAX_RADIUS_DEF,
   parameter int PIXEL_BITS = mps_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [PIXEL_BITS-1:0]              req_pixel,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mps_pkg::POOL_W-1:0]         rsp_pooled,
   output logic [mps_pkg::OCOL_W-1:0]         rsp_out_col,
   output logic [mps_pkg::OROW_W-1:0]         rsp_out_row,
   output logic                               rsp_frame_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mps_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int GW = mps_pkg::GEO_W;
   localparam int QW = PIXEL_BITS + $bits(mps_pkg::beat_meta_type);

   logic [10:0]  width_ff;
   logic [12:0]  height_ff;
   logic [2:0]   radius_ff;
   logic [4:0]   stride_ff;
   logic         csr_write;
   mps_pkg::geom_type       geom;
   logic [mps_pkg::RAD_W-1:0] rad_eff;
   logic [mps_pkg::STR_W-1:0] str_eff;

   logic                    f_valid, f_ready, b_valid, b_ready;
   logic [PIXEL_BITS-1:0]   f_pixel, b_pixel;
   mps_pkg::beat_meta_type  f_meta, b_meta;
   logic [QW-1:0]           b_data;
   logic [$clog2(5)-1:0]    q_count;

   // registers are always writable; the user writes them only while idle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mps_pkg::WIDTH_RST;
         height_ff <= mps_pkg::HEIGHT_RST;
         radius_ff <= mps_pkg::RADIUS_RST;
         stride_ff <= mps_pkg::STRIDE_RST;
      end else if (csr_write) begin
         case (mps_pkg::csr_index_type'(csr_index))
            mps_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata[10:0];
            mps_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata[12:0];
            mps_pkg::CSR_WINDOW_RADIUS: radius_ff <= csr_wdata[2:0];
            mps_pkg::CSR_POOL_STRIDE:   stride_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // clamp the register values into the legal geometry
   always_comb begin
      if (width_ff == '0) begin
         geom.width = GW'(1);
      end else if (GW'(width_ff) > GW'(MAX_WIDTH)) begin
         geom.width = GW'(MAX_WIDTH);
      end else begin
         geom.width = GW'(width_ff);
      end
      if (height_ff == '0) begin
         geom.height = GW'(1);
      end else if (height_ff > GW'(mps_pkg::MAX_HEIGHT)) begin
         geom.height = GW'(mps_pkg::MAX_HEIGHT);
      end else begin
         geom.height = height_ff;
      end
      rad_eff = (mps_pkg::RAD_W'(radius_ff) > mps_pkg::RAD_W'(MAX_RADIUS)) ?
                mps_pkg::RAD_W'(MAX_RADIUS) : mps_pkg::RAD_W'(radius_ff);
      str_eff = (stride_ff == '0) ? mps_pkg::STR_W'(1) : stride_ff;
      geom.radius     = rad_eff;
      geom.span       = {rad_eff, 1'b0};
      geom.stride     = str_eff;
      geom.radius_div = mps_pkg::div_small(rad_eff, str_eff);
   end

   mps_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .geom           (geom),
      .resync_start   (csr_write),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_pixel       (req_pixel),
      .in_frame_start (req_frame_start),
      .push_valid     (f_valid),
      .push_ready     (f_ready),
      .push_pixel     (f_pixel),
      .push_meta      (f_meta)
   );

   // hold classified beats so front and back stall independently
   mps_queue #(
      .WIDTH (QW),
      .DEPTH (4)
   ) u_beat_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_pixel, f_meta}),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data),
      .count      (q_count)
   );

   assign b_pixel = b_data[QW-1 -: PIXEL_BITS];
   assign b_meta  = mps_pkg::beat_meta_type'(b_data[$bits(mps_pkg::beat_meta_type)-1:0]);

   mps_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .in_valid   (b_valid),
      .in_ready   (b_ready),
      .in_pixel   (b_pixel),
      .in_meta    (b_meta),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_pooled (rsp_pooled),
      .out_col    (rsp_out_col),
      .out_row    (rsp_out_row),
      .out_last   (rsp_frame_last)
   );

   `MPS_ASSERT(a_q_bound, q_count <= 3'd4, "beat queue count out of range")
   `MPS_ASSERT_IMPL(a_accept_push, req_valid && req_ready, f_valid && f_ready, "beat lost at front")
   `MPS_ASSERT_IMPL(a_cfg_block, csr_write, ##1 !req_ready, "beats taken during resync")

endmodule

// ===== tb/sv/max_pool_subsample_top_test.sv =====
// Self-checking bench for max_pool_subsample_top: streams raster frames under many
// geometry settings and checks pooled results against a predictor held in a class.
// Depends on mps_pkg and the max_pool_subsample_top RTL.
module max_pool_subsample_top_test;

   localparam int STORE_ROWS  = 14;
   localparam int STORE_COLS  = 1024;
   localparam int WINDOW_LEN  = 15;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 16;

   typedef struct packed {
      logic [15:0] pooled;
      logic [9:0]  out_col;
      logic [11:0] out_row;
      logic        frame_last;
   } pool_result_type;

   // Predictor of the pooled stream plus the queue of results not yet seen.
   class pool_scoreboard;
      bit [10:0] image_width  = 11'd640;
      bit [12:0] image_height = 13'd480;
      bit [2:0]  window_radius = 3'd4;
      bit [4:0]  pool_stride  = 5'd5;
      bit [15:0] line_rows [STORE_ROWS][STORE_COLS];
      bit [15:0] col_maxima [WINDOW_LEN];
      int unsigned col_pos;
      int unsigned row_pos;
      pool_result_type pooled_due [$];
      int errors;
      int results_due;

      function int unsigned eff_width();
         if (image_width == 0) return 1;
         if (image_width > STORE_COLS) return STORE_COLS;
         return image_width;
      endfunction

      function int unsigned eff_height();
         if (image_height == 0) return 1;
         if (image_height > 4096) return 4096;
         return image_height;
      endfunction

      function void set_reg(mps_pkg::csr_index_type idx, bit [12:0] value);
         case (idx)
            mps_pkg::CSR_IMAGE_WIDTH:   image_width   = value[10:0];
            mps_pkg::CSR_IMAGE_HEIGHT:  image_height  = value;
            mps_pkg::CSR_WINDOW_RADIUS: window_radius = value[2:0];
            mps_pkg::CSR_POOL_STRIDE:   pool_stride   = value[4:0];
            default: ;
         endcase
      endfunction

      // True when the raster position lies outside the current geometry.
      function bit position_outside();
         return (col_pos >= eff_width()) || (row_pos >= eff_height());
      endfunction

      function void note_pixel(bit [15:0] pix, bit frame_start);
         int unsigned w, h, s, span, c, rr, bank, best;
         bit [15:0] colmax;
         pool_result_type res;
         w = eff_width();
         h = eff_height();
         s = (pool_stride == 0) ? 1 : pool_stride;
         span = 2 * window_radius;
         if (frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         c = col_pos % STORE_COLS;
         rr = row_pos % 4096;
         bank = rr % STORE_ROWS;
         // vertical max over this pixel and the rows held above it
         colmax = pix;
         for (int k = 1; k <= span; k++)
            if (line_rows[(bank + STORE_ROWS - k) % STORE_ROWS][c] > colmax)
               colmax = line_rows[(bank + STORE_ROWS - k) % STORE_ROWS][c];
         line_rows[bank][c] = pix;
         for (int k = WINDOW_LEN - 1; k > 0; k--) col_maxima[k] = col_maxima[k-1];
         col_maxima[0] = colmax;
         if (c < w && rr < h && c >= span && rr >= span &&
             (c - span) % s == 0 && (rr - span) % s == 0) begin
            best = 0;
            for (int k = 0; k <= span; k++)
               if (col_maxima[k] > best) best = col_maxima[k];
            res.pooled     = best[15:0];
            res.out_col    = 10'((c - window_radius) / s);
            res.out_row    = 12'((rr - window_radius) / s);
            res.frame_last = (c + s >= w) && (rr + s >= h);
            pooled_due.push_back(res);
            results_due++;
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (rr + 1 >= h) ? 0 : rr + 1;
         end else begin
            col_pos = c + 1;
            row_pos = rr;
         end
      endfunction

      function void check_result(pool_result_type got);
         pool_result_type want;
         if (pooled_due.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = pooled_due.pop_front();
         if (got.pooled !== want.pooled) begin
            $display("%0t pooled: expected %h actual %h", $time, want.pooled, got.pooled);
            errors++;
         end
         if (got.out_col !== want.out_col) begin
            $display("%0t out_col: expected %0d actual %0d", $time, want.out_col,
                     got.out_col);
            errors++;
         end
         if (got.out_row !== want.out_row) begin
            $display("%0t out_row: expected %0d actual %0d", $time, want.out_row,
                     got.out_row);
            errors++;
         end
         if (got.frame_last !== want.frame_last) begin
            $display("%0t frame_last: expected %b actual %b", $time, want.frame_last,
                     got.frame_last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_pixel = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [mps_pkg::POOL_W-1:0] rsp_pooled;
   logic [mps_pkg::OCOL_W-1:0] rsp_out_col;
   logic [mps_pkg::OROW_W-1:0] rsp_out_row;
   logic        rsp_frame_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [mps_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mps_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pool_scoreboard sb = new();
   int unsigned cycle_count = 0;
   int unsigned pixels_sent = 0;
   bit hold_off_armed = 1'b0;
   int burst_left = 0;

   max_pool_subsample_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel(req_pixel), .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pooled(rsp_pooled), .rsp_out_col(rsp_out_col),
      .rsp_out_row(rsp_out_row), .rsp_frame_last(rsp_frame_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: the slowest legal run is far below this, including the tracker
   // walk the block does after reset and after every register write.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("max_pool_subsample_top_test failed");
         $finish;
      end
   end

   // Result side: check every accepted beat, then pick the next ready value.
   // The stall pattern steps in turn through three modes: none, short and
   // frequent, or long and rare. A long hold-off is taken once on request.
   initial begin : result_side
      int stall_left;
      int hold_left;
      int mode;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_pooled, rsp_out_col, rsp_out_row, rsp_frame_last});
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_left = 300;
         end
         mode = (cycle_count / 400) % 3;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (mode == 1 && $urandom_range(0, 2) == 0)
               stall_left = $urandom_range(1, 3);
            else if (mode == 2 && $urandom_range(0, 15) == 0)
               stall_left = $urandom_range(5, 25);
         end
      end
   end

   // Offer one pixel beat and hold it until accepted, then predict it.
   task automatic drive_pixel(input bit [15:0] pix, input bit frame_start);
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pixel(pix, frame_start);
      pixels_sent++;
   endtask

   // Write all four geometry registers back to back, holding csr_valid.
   task automatic program_geometry(input bit [10:0] w, input bit [12:0] h,
                                   input bit [2:0] r, input bit [4:0] s);
      mps_pkg::csr_index_type idx [4];
      bit [12:0] val [4];
      idx = '{mps_pkg::CSR_IMAGE_WIDTH, mps_pkg::CSR_IMAGE_HEIGHT,
              mps_pkg::CSR_WINDOW_RADIUS, mps_pkg::CSR_POOL_STRIDE};
      val = '{13'(w), h, 13'(r), 13'(s)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_reg(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Drop valid, then wait for every expected result plus the pipeline tail.
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pooled_due.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic bit [15:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Stream n pixels in bursts with random gaps; the first pixel starts a frame
   // unless the raster position already lies outside the new geometry, in which
   // case it is left to wrap on its own.
   task automatic send_phase(input int n);
      int gap;
      bit fs;
      for (int i = 0; i < n; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         if (i == 0) fs = !sb.position_outside();
         else fs = ($urandom_range(0, 59) == 0);
         drive_pixel(pick_pixel(), fs);
      end
   endtask

   initial begin : stimulus
      bit [10:0] w;
      bit [12:0] h;
      bit [2:0]  r;
      bit [4:0]  s;
      int unsigned frame_px;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A few pixels under the reset geometry; none can produce a result yet.
      for (int i = 0; i < 4; i++) drive_pixel(pick_pixel(), i == 0);
      drain();

      // Directed: 3x3 window of stride 1, extremes in the first and last positions.
      program_geometry(11'd3, 13'd3, 3'd1, 5'd1);
      drive_pixel(16'hFFFF, 1'b1);
      for (int i = 1; i < 9; i++) drive_pixel(16'h0000, 1'b0);
      drive_pixel(16'h0000, 1'b1);
      for (int i = 1; i < 8; i++) drive_pixel(16'h7FFF, 1'b0);
      drive_pixel(16'hFFFF, 1'b0);
      drain();
      // Directed: zero radius, every pixel is its own window; the second frame
      // follows without a frame_start and wraps on its own.
      program_geometry(11'd2, 13'd2, 3'd0, 5'd1);
      drive_pixel(16'h8000, 1'b1);
      drive_pixel(16'h0001, 1'b0);
      drive_pixel(16'hFFFE, 1'b0);
      drive_pixel(16'h0000, 1'b0);
      for (int i = 0; i < 4; i++) drive_pixel(16'h5555 << i, 1'b0);
      drain();

      // Fill the result queue while the receiver holds off.
      program_geometry(11'd8, 13'd8, 3'd0, 5'd1);
      hold_off_armed = 1'b1;
      send_phase(64);
      drain();

      // Random phases: mostly small frames, some extreme registers.
      while (pixels_sent < 1400 || sb.results_due < 60) begin
         case ($urandom_range(0, 9))
            0: begin
               w = ($urandom_range(0, 1) == 0) ? 11'd0 :
                   (($urandom_range(0, 1) == 0) ? 11'd1024 : 11'($urandom_range(1025, 2047)));
               h = 13'($urandom_range(1, 20));
            end
            1: begin
               w = 11'($urandom_range(1, 24));
               h = ($urandom_range(0, 1) == 0) ? 13'd0 :
                   (($urandom_range(0, 1) == 0) ? 13'd4096 : 13'($urandom_range(4097, 8191)));
            end
            default: begin
               w = 11'($urandom_range(1, 24));
               h = 13'($urandom_range(1, 24));
            end
         endcase
         r = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: s = 5'd0;
            1: s = 5'($urandom_range(17, 31));
            default: s = 5'($urandom_range(1, 16));
         endcase
         program_geometry(w, h, r, s);
         frame_px = sb.eff_width() * sb.eff_height();
         n = (frame_px * $urandom_range(1, 3) > 160) ? 160 : frame_px * $urandom_range(1, 3);
         send_phase(n);
         drain();
      end

      if (sb.pooled_due.size() != 0) begin
         $display("%0t results missing: expected %0d more actual 0", $time,
                  sb.pooled_due.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("max_pool_subsample_top_test passed");
      end else begin
         $display("max_pool_subsample_top_test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/mps_pkg.sv
design/mps_queue.sv
design/mps_front.sv
design/mps_back.sv
design/max_pool_subsample_top.sv
tb/sv/max_pool_subsample_top_test.sv
